// File: hw/rtl/fifo_write_back_cache_assert.svh
// Assertion macros used by the top-level cache RTL file.
`ifndef FIFO_WRITE_BACK_CACHE_ASSERT_SVH
`define FIFO_WRITE_BACK_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FWBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FWBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fwbc_pkg.sv
// Shared constants, types and helpers for the write-back cache.
package fwbc_pkg;

    localparam int ENTRIES    = 8;
    localparam int MEM_WORDS  = 32;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int ADDR_W = $clog2(MEM_WORDS);

    // Stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_STORE = 2'd1,
        CMD_IMAGE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WB,
        ST_FILL,
        ST_DONE
    } t_state;

    // Line store write request
    typedef struct packed {
        logic                  en;
        logic                  fill;   // also write tag and set valid
        logic [IDX_W-1:0]      idx;
        logic [ADDR_W-1:0]     tag;
        logic [DATA_WIDTH-1:0] data;
    } t_line_wr;

    // Line store lookup response
    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [DATA_WIDTH-1:0] rd_data;      // hit line, else victim line
        logic                  victim_valid;
        logic [ADDR_W-1:0]     victim_tag;
    } t_line_rsp;

    // 32-bit port word to line word
    function automatic logic [DATA_WIDTH-1:0] to_line(input logic [31:0] w);
        logic [63:0] t;
        t = {32'b0, w};
        return t[DATA_WIDTH-1:0];
    endfunction

    // Line word to 32-bit port word
    function automatic logic [31:0] from_line(input logic [DATA_WIDTH-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

endpackage

// File: hw/rtl/fwbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/fwbc_lines.sv
// Cache line store: tags, data, valid bits and parallel tag match.
module fwbc_lines (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [fwbc_pkg::ADDR_W-1:0] i_addr,
    input  logic [fwbc_pkg::IDX_W-1:0]  i_fill_ptr,
    input  fwbc_pkg::t_line_wr          i_wr,
    output fwbc_pkg::t_line_rsp         o_rsp
);
    import fwbc_pkg::*;

    logic [ADDR_W-1:0]     r_tag  [ENTRIES];
    logic [DATA_WIDTH-1:0] r_data [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;

    logic [ENTRIES-1:0]    match;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      rd_idx;

    // Per-entry compare; valid tags are unique, so OR-encode the index
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tag[i] == i_addr);
            if (match[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    // Single read port: hit line on a hit, victim line on a miss
    assign rd_idx = (|match) ? hit_idx : i_fill_ptr;

    always_comb begin
        o_rsp.hit          = |match;
        o_rsp.hit_idx      = hit_idx;
        o_rsp.rd_data      = r_data[rd_idx];
        o_rsp.victim_valid = r_valid[i_fill_ptr];
        o_rsp.victim_tag   = r_tag[i_fill_ptr];
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en && i_wr.fill) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    // Tag and data storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_data[i_wr.idx] <= i_wr.data;
            if (i_wr.fill) begin
                r_tag[i_wr.idx] <= i_wr.tag;
            end
        end
    end

endmodule

// File: hw/rtl/fifo_write_back_cache.sv
// Sequencer: each accepted transaction passes through lookup, then on a miss a write-back
// of the victim if it is valid and a fill, then done, where the result register loads.
// A new transaction is accepted only in idle, after the last result has loaded; the sequencer
// shares the one write and one read port of the backing RAM.
// Reset (synchronous, active low) clears line valid bits, fill pointer and output valid;
// tags, line data and backing memory hold no value until written.
`include "fifo_write_back_cache_assert.svh"

module fifo_write_back_cache (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: base_address[31:0], offset[47:32], write_data[79:48]
    input  logic [fwbc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: command[1:0]
    input  logic [fwbc_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: read_data[31:0]
    output logic [fwbc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: hit[0], addr_error[1]
    output logic [fwbc_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import fwbc_pkg::*;

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_err;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [IDX_W-1:0]      r_fill_ptr, n_fill_ptr;
    logic [31:0]           r_res_rd, n_res_rd;
    logic                  r_res_hit, n_res_hit;
    logic                  r_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data;
    logic [M_TUSER_W-1:0]  r_m_user;

    logic                  accept;
    logic                  out_load;
    logic                  is_load;
    logic [32:0]           ea;
    logic                  ea_bad;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [DATA_WIDTH-1:0] ram_rdata;

    t_line_wr              line_wr;
    t_line_rsp             line_rsp;

    // Effective address and range check at accept
    assign ea = {s_axis_tdata[31], s_axis_tdata[31:0]}
              + {{17{s_axis_tdata[47]}}, s_axis_tdata[47:32]};
    assign ea_bad = ea[32] || (ea[31:0] >= 32'(MEM_WORDS));

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign is_load = (r_cmd == CMD_LOAD);

    fwbc_lines u_lines (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (r_addr),
        .i_fill_ptr (r_fill_ptr),
        .i_wr       (line_wr),
        .o_rsp      (line_rsp)
    );

    fwbc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (r_cmd == CMD_NOP || r_err || r_cmd == CMD_IMAGE || line_rsp.hit) begin
                    n_state = ST_DONE;
                end else if (line_rsp.victim_valid) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_FILL;
                end
            end
            ST_WB:   n_state = ST_FILL;
            ST_FILL: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath next values
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_wdata     = r_wdata;
        ram_re        = 1'b0;
        line_wr       = '0;
        line_wr.idx   = r_fill_ptr;
        line_wr.tag   = r_addr;
        line_wr.data  = r_wdata;
        n_fill_ptr    = r_fill_ptr;
        n_res_rd      = r_res_rd;
        n_res_hit     = r_res_hit;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_LOOKUP: begin
                // fetch the fill word early; a write-back never hits this address
                ram_re    = 1'b1;
                n_res_rd  = '0;
                n_res_hit = 1'b0;
                if (r_cmd == CMD_NOP || r_err) begin
                end else if (r_cmd == CMD_IMAGE) begin
                    ram_we = 1'b1;
                end else if (line_rsp.hit) begin
                    n_res_hit = 1'b1;
                    if (is_load) begin
                        n_res_rd = from_line(line_rsp.rd_data);
                    end else begin
                        line_wr.en  = 1'b1;
                        line_wr.idx = line_rsp.hit_idx;
                    end
                end
            end
            ST_WB: begin
                // victim always written back, no dirty tracking
                ram_we    = 1'b1;
                ram_waddr = line_rsp.victim_tag;
                ram_wdata = line_rsp.rd_data;
            end
            ST_FILL: begin
                line_wr.en   = 1'b1;
                line_wr.fill = 1'b1;
                if (is_load) begin
                    line_wr.data = ram_rdata;
                    n_res_rd     = from_line(ram_rdata);
                end
                n_fill_ptr = (r_fill_ptr == IDX_W'(ENTRIES - 1)) ? '0 : r_fill_ptr + 1'b1;
            end
            ST_DONE: begin
                out_load = !r_m_valid || m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill_ptr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill_ptr <= n_fill_ptr;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(s_axis_tuser[1:0]);
            r_addr  <= ea[ADDR_W-1:0];
            r_err   <= ea_bad && (t_cmd'(s_axis_tuser[1:0]) != CMD_NOP);
            r_wdata <= to_line(s_axis_tdata[79:48]);
        end
        r_res_rd  <= n_res_rd;
        r_res_hit <= n_res_hit;
        if (out_load) begin
            r_m_data <= r_res_rd;
            r_m_user <= {r_err, r_res_hit};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `FWBC_ASSERT_NEXT(a_accept_starts_lookup, accept, r_state == ST_LOOKUP, "accept did not start lookup")
    `FWBC_ASSERT_NOW(a_hit_err_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "hit with address error")
    `FWBC_ASSERT_NEXT(a_ptr_moves_on_fill, r_state != ST_FILL, $stable(r_fill_ptr), "fill pointer moved outside fill")
    `FWBC_ASSERT_NOW(a_ram_write_states, ram_we, r_state == ST_LOOKUP || r_state == ST_WB, "backing write in wrong state")
    `FWBC_ASSERT_NOW(a_wb_needs_valid, r_state == ST_WB, line_rsp.victim_valid && !line_rsp.hit, "write-back of invalid victim")

endmodule

// File: dv/fifo_write_back_cache_checker.sv
// Checker for the write-back cache: tracks both stream channels, predicts and compares results.
`timescale 1ns / 1ps

module fifo_write_back_cache_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: base_address[31:0], offset[47:32], write_data[79:48]
    input  logic [fwbc_pkg::S_TDATA_W-1:0] i_s_tdata,
    // tuser: command[1:0]
    input  logic [fwbc_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // tdata: read_data[31:0]
    input  logic [fwbc_pkg::M_TDATA_W-1:0] i_m_tdata,
    // tuser: hit[0], addr_error[1]
    input  logic [fwbc_pkg::M_TUSER_W-1:0] i_m_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import fwbc_pkg::*;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
        logic        addr_error;
    } t_cache_rsp;

    // Shadow copy of the cache and the memory behind it
    logic [ADDR_W-1:0]     line_tag   [ENTRIES];
    logic [DATA_WIDTH-1:0] line_data  [ENTRIES];
    logic [ENTRIES-1:0]    line_valid;
    logic [IDX_W-1:0]      fill_ptr;
    logic [DATA_WIDTH-1:0] backing_mem [MEM_WORDS];

    t_cache_rsp expected_rsp_q [$];
    int         fails = 0;

    // Applies one request to the shadow state and returns the response it should produce
    function automatic t_cache_rsp cache_access(input t_cmd cmd, input logic [31:0] base,
                                                input logic [15:0] off,
                                                input logic [31:0] wdata);
        t_cache_rsp        rsp;
        longint            ea;
        logic [ADDR_W-1:0] addr;
        logic [IDX_W-1:0]  victim;
        rsp = '0;
        ea  = longint'($signed(base)) + longint'($signed(off));
        if (cmd == CMD_NOP) begin
            return rsp;
        end
        if (ea < 0 || ea >= MEM_WORDS) begin
            rsp.addr_error = 1'b1;
            return rsp;
        end
        addr = ea[ADDR_W-1:0];
        // image write goes straight to memory, cache untouched
        if (cmd == CMD_IMAGE) begin
            backing_mem[addr] = wdata[DATA_WIDTH-1:0];
            return rsp;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && line_tag[i] == addr) begin
                rsp.hit = 1'b1;
                if (cmd == CMD_LOAD) begin
                    rsp.read_data = 32'(line_data[i]);
                end else begin
                    line_data[i] = wdata[DATA_WIDTH-1:0];
                end
                return rsp;
            end
        end
        // miss: round-robin victim, always written back when valid
        victim = fill_ptr;
        if (line_valid[victim]) begin
            backing_mem[line_tag[victim]] = line_data[victim];
        end
        line_tag[victim]   = addr;
        line_valid[victim] = 1'b1;
        line_data[victim]  = (cmd == CMD_LOAD) ? backing_mem[addr] : wdata[DATA_WIDTH-1:0];
        fill_ptr           = victim + 1'b1;
        if (cmd == CMD_LOAD) begin
            rsp.read_data = 32'(line_data[victim]);
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_cache_rsp want;
        if (!i_rst_n) begin
            line_valid = '0;
            fill_ptr   = '0;
            expected_rsp_q.delete();
        end else begin
            // result transaction: compare against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    fails++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_m_tdata !== want.read_data) begin
                        $error("read_data: expected %h, actual %h", want.read_data, i_m_tdata);
                        fails++;
                    end
                    if (i_m_tuser[0] !== want.hit) begin
                        $error("hit: expected %b, actual %b", want.hit, i_m_tuser[0]);
                        fails++;
                    end
                    if (i_m_tuser[1] !== want.addr_error) begin
                        $error("addr_error: expected %b, actual %b", want.addr_error,
                               i_m_tuser[1]);
                        fails++;
                    end
                end
            end
            // request transaction: predict
            if (i_s_tvalid && i_s_tready) begin
                expected_rsp_q.push_back(cache_access(t_cmd'(i_s_tuser), i_s_tdata[31:0],
                                                      i_s_tdata[47:32], i_s_tdata[79:48]));
            end
        end
        o_pending    <= expected_rsp_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: dv/fifo_write_back_cache_tb.sv
// Testbench top for the write-back cache: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module fifo_write_back_cache_tb;
    import fwbc_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 5_000;
    localparam int RANDOM_ITEMS = 1_500;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;

    int fail_count;
    int pending;
    int cycle_cnt = 0;

    // words that hold a defined value, either in memory or in a cache line
    logic [MEM_WORDS-1:0] known_words = '0;
    bit                   tx_quiet    = 1'b0;
    bit                   rx_quiet    = 1'b0;
    int                   rx_stall    = 0;
    int                   rx_phase    = 0;

    fifo_write_back_cache i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    fifo_write_back_cache_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Idle length: mostly short, occasionally long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure, with stall-free stretches
    always @(posedge i_clk) begin
        rx_phase++;
        if (rx_phase % 256 == 0) begin
            rx_quiet = ($urandom_range(0, 9) < 3);
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else if (!rx_quiet && $urandom_range(0, 99) < 20) begin
            rx_stall = gap_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Send one request transaction; a load of a never-written word becomes an image write
    task automatic issue(input t_cmd cmd, input logic [31:0] base, input logic [15:0] off,
                         input logic [31:0] wdata);
        longint ea;
        t_cmd   c;
        int     gap;
        c  = cmd;
        ea = longint'($signed(base)) + longint'($signed(off));
        if (ea >= 0 && ea < MEM_WORDS) begin
            if (c == CMD_LOAD && !known_words[int'(ea)]) begin
                c = CMD_IMAGE;
            end
            if (c == CMD_STORE || c == CMD_IMAGE) begin
                known_words[int'(ea)] = 1'b1;
            end
        end
        s_axis_tdata  <= {wdata, off, base};
        s_axis_tuser  <= c;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        gap = (tx_quiet || $urandom_range(0, 99) < 55) ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int          r;
        int          target;
        int          drain;
        t_cmd        cmd;
        logic [15:0] off;
        logic [31:0] base;
        logic [31:0] wd;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: data extremes, hit and miss paths
        issue(CMD_IMAGE, 32'd0,         16'd0,      32'h0000_0000);
        issue(CMD_IMAGE, 32'd31,        16'd0,      32'hFFFF_FFFF);
        issue(CMD_IMAGE, 32'd38,        16'hFFE0,   32'h7FFF_FFFF);
        issue(CMD_LOAD,  32'd0,         16'd0,      32'hDEAD_BEEF);
        issue(CMD_LOAD,  32'd0,         16'd0,      32'h0);
        issue(CMD_LOAD,  32'd32799,     16'h8000,   32'h0);
        issue(CMD_STORE, 32'd5,         16'd0,      32'h8000_0000);
        issue(CMD_LOAD,  32'd5,         16'd0,      32'h0);
        // image write under a cached copy: the cached word wins
        issue(CMD_IMAGE, 32'd0,         16'd0,      32'h1234_5678);
        issue(CMD_LOAD,  32'd0,         16'd0,      32'h0);
        issue(CMD_NOP,   32'hFFFF_FFFF, 16'h7FFF,   32'hFFFF_FFFF);
        // out-of-range addresses, each command, sum overflowing 32 bits
        issue(CMD_LOAD,  32'd32,        16'd0,      32'h0);
        issue(CMD_STORE, 32'hFFFF_FFFF, 16'd0,      32'hFFFF_FFFF);
        issue(CMD_IMAGE, 32'h7FFF_FFFF, 16'h7FFF,   32'hA5A5_A5A5);
        issue(CMD_LOAD,  32'h8000_0000, 16'h8000,   32'h0);
        issue(CMD_STORE, 32'h7FFF_FFFF, 16'h8000,   32'h5A5A_5A5A);
        // fill remaining lines, wrap the pointer, evict with write-back
        issue(CMD_STORE, 32'd6,         16'd0,      32'h0);
        issue(CMD_STORE, 32'd5,         16'd0,      32'hFFFF_FFFF);
        for (int a = 10; a < 14; a++) begin
            issue(CMD_STORE, 32'(a),    16'd0,      32'(a * 32'h0101_0101));
        end
        issue(CMD_STORE, 32'd14,        16'd0,      32'hC0DE_0014);
        // write-back of the evicted copy overwrote the image word
        issue(CMD_LOAD,  32'd0,         16'd0,      32'h0);
        issue(CMD_LOAD,  32'd31,        16'd0,      32'h0);
        wait_idle();

        // Random: mostly in-range traffic on a small hot set
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                tx_quiet = ($urandom_range(0, 9) < 3);
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                cmd = CMD_LOAD;
            end else if (r < 75) begin
                cmd = CMD_STORE;
            end else if (r < 92) begin
                cmd = CMD_IMAGE;
            end else begin
                cmd = CMD_NOP;
            end
            off = 16'($urandom);
            r   = $urandom_range(0, 99);
            if (r < 80) begin
                target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, 11);
                base   = 32'(target) - {{16{off[15]}}, off};
            end else if (r < 90) begin
                case ($urandom_range(0, 5))
                    0:       target = -2;
                    1:       target = -1;
                    2:       target = 32;
                    3:       target = 33;
                    4:       target = 0;
                    default: target = 31;
                endcase
                base = 32'(target) - {{16{off[15]}}, off};
            end else begin
                base = $urandom;
            end
            r = $urandom_range(0, 19);
            wd = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            issue(cmd, base, off, wd);
            if ($urandom_range(0, 99) == 0) begin
                wait_idle();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain and let the pipeline settle
        drain = 0;
        @(posedge i_clk);
        while (pending != 0 && drain < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (12) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
